// ----- rtl/core/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants, types and the neighbor-count rule for the Life stencil.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int LGS_MAX_COLS = 32;
    localparam int LGS_MAX_ROWS = 32;

    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int ROW_W       = $clog2(LGS_MAX_ROWS);
    localparam int OUT_COORD_W = 5;
    localparam int ENTRY_W     = 2;

    localparam logic [CFG_W-1:0] SIZE_RESET = 6'd20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    localparam logic [3:0] LIVE_BIRTH = 4'd3;
    localparam logic [3:0] LIVE_KEEP  = 4'd2;

    // one column of the 3x3 window: {upper, middle, lower}
    typedef logic [2:0] col3_t;

    function automatic logic life_next(col3_t lft, col3_t ctr, col3_t rgt);
        logic [3:0] cnt;
        cnt = 4'(lft[2]) + 4'(lft[1]) + 4'(lft[0])
            + 4'(rgt[2]) + 4'(rgt[1]) + 4'(rgt[0])
            + 4'(ctr[2]) + 4'(ctr[0]);
        return (cnt == LIVE_BIRTH) || ((cnt == LIVE_KEEP) && ctr[1]);
    endfunction

endpackage

// ----- rtl/core/life_generation_stencil.sv -----
// ----------------------------------------------------------------------------
// life_generation_stencil
// One Life generation over a bounded grid, cells streamed in raster order.
// A cell is taken in S_IDLE, then S_CALC does the memory read-modify-write;
// in_ready is low until that cell is done, and a full output stalls it.
// A last-column cell emits a second result in S_EM1; the frame's final cell
// adds a row flush that reads, loads and emits each column in turn.
// Reset: size registers to 20x20, positions to row 0 column 0; a size
// write also restarts the frame. The column memory needs no clearing.
// ----------------------------------------------------------------------------
module life_generation_stencil
    import lgs_pkg::*;
#(
    parameter int MAX_COLS = LGS_MAX_COLS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   cell_alive,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   next_alive,
    output logic [OUT_COORD_W-1:0] out_row,
    output logic [OUT_COORD_W-1:0] out_col,
    output logic                   run_last
);

    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int COL_CNT_W = $clog2(MAX_COLS + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CALC    = 3'd1;
    localparam logic [2:0] S_EM0     = 3'd2;
    localparam logic [2:0] S_EM1     = 3'd3;
    localparam logic [2:0] S_FRD     = 3'd4;
    localparam logic [2:0] S_FLD     = 3'd5;
    localparam logic [2:0] S_FEM     = 3'd6;
    localparam logic [2:0] S_FEMLAST = 3'd7;

    logic [CFG_W-1:0]     rows_eff;
    logic [COL_CNT_W-1:0] cols_eff;

    logic [2:0]       state_reg, state_next;
    logic [ROW_W-1:0] pos_row_reg, pos_row_next;
    logic [COL_W-1:0] pos_col_reg, pos_col_next;
    logic [ROW_W-1:0] cur_row_reg;
    logic [COL_W-1:0] cur_col_reg;
    logic             cell_reg;
    logic             col_last_reg;
    logic             final_reg;
    logic [COL_W-1:0] fptr_reg, fptr_next;
    col3_t            p0_reg, p0_next;
    col3_t            p1_reg, p1_next;
    col3_t            p2_reg, p2_next;

    logic                   out_valid_reg;
    logic                   next_alive_reg;
    logic [OUT_COORD_W-1:0] out_row_reg;
    logic [OUT_COORD_W-1:0] out_col_reg;
    logic                   run_last_reg;

    logic             accept;
    logic             pos_col_last;
    logic             pos_row_last;
    logic             fptr_last;
    logic             e0, e1;
    logic [2:0]       after_e0;
    logic             out_free;
    logic             ld;
    logic             ld_alive;
    logic [COL_W-1:0] ld_col;
    logic [ROW_W-1:0] ld_row;
    logic             ld_last;
    logic             mem_we;
    logic [COL_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    col3_t            new_col;
    col3_t            fl_col;

    lgs_cfg #(
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rows_eff  (rows_eff),
        .cols_eff  (cols_eff)
    );

    lgs_row_mem #(
        .DEPTH (MAX_COLS)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (cur_col_reg),
        .wr_data (new_col[1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign pos_col_last = (COL_CNT_W'(pos_col_reg) + COL_CNT_W'(1)) == cols_eff;
    assign pos_row_last = (CFG_W'(pos_row_reg) + CFG_W'(1)) == rows_eff;
    assign fptr_last    = (COL_CNT_W'(fptr_reg) + COL_CNT_W'(1)) == cols_eff;

    assign e0 = (cur_row_reg != '0) && (cur_col_reg != '0);
    assign e1 = (cur_row_reg != '0) && col_last_reg;
    assign after_e0 = e1 ? S_EM1 : (final_reg ? S_FRD : S_IDLE);

    // memory entry is {row r-2, row r-1}; rows above the frame read as dead
    assign new_col = {(cur_row_reg > ROW_W'(1)) ? rd_data[1] : 1'b0,
                      (cur_row_reg != '0)       ? rd_data[0] : 1'b0,
                      cell_reg};
    // during the flush the entry is {row r-1, row r}; below is dead
    assign fl_col = {rd_data[1], rd_data[0], 1'b0};

    always_comb
    begin
        state_next = state_reg;
        fptr_next  = fptr_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        ld         = 1'b0;
        ld_alive   = 1'b0;
        ld_col     = cur_col_reg - COL_W'(1);
        ld_row     = cur_row_reg - ROW_W'(1);
        ld_last    = 1'b0;
        mem_we     = 1'b0;
        rd_addr    = pos_col_reg;

        case (state_reg)
            S_IDLE:
            begin
                fptr_next = '0;
                if (in_valid)
                    state_next = S_CALC;
            end
            S_CALC:
            begin
                mem_we = 1'b1;
                if (cur_col_reg == '0)
                begin
                    p2_next = '0;
                    p1_next = '0;
                end
                else
                begin
                    p2_next = p1_reg;
                    p1_next = p0_reg;
                end
                p0_next = new_col;
                if (e0)
                begin
                    if (out_free)
                    begin
                        ld         = 1'b1;
                        ld_alive   = life_next(p1_reg, p0_reg, new_col);
                        ld_last    = !(e1 || final_reg);
                        state_next = after_e0;
                    end
                    else
                    begin
                        state_next = S_EM0;
                    end
                end
                else
                begin
                    state_next = after_e0;
                end
            end
            S_EM0:
            begin
                if (out_free)
                begin
                    ld         = 1'b1;
                    ld_alive   = life_next(p2_reg, p1_reg, p0_reg);
                    ld_last    = !(e1 || final_reg);
                    state_next = after_e0;
                end
            end
            S_EM1:
            begin
                ld_col = cur_col_reg;
                if (out_free)
                begin
                    ld         = 1'b1;
                    ld_alive   = life_next(p1_reg, p0_reg, '0);
                    ld_last    = !final_reg;
                    state_next = final_reg ? S_FRD : S_IDLE;
                end
            end
            S_FRD:
            begin
                rd_addr    = fptr_reg;
                state_next = S_FLD;
            end
            S_FLD:
            begin
                if (fptr_reg == '0)
                begin
                    p2_next = '0;
                    p1_next = '0;
                end
                else
                begin
                    p2_next = p1_reg;
                    p1_next = p0_reg;
                end
                p0_next = fl_col;
                if (fptr_reg != '0)
                    state_next = S_FEM;
                else if (fptr_last)
                    state_next = S_FEMLAST;
                else
                begin
                    fptr_next  = fptr_reg + COL_W'(1);
                    state_next = S_FRD;
                end
            end
            S_FEM:
            begin
                ld_row = cur_row_reg;
                ld_col = fptr_reg - COL_W'(1);
                if (out_free)
                begin
                    ld       = 1'b1;
                    ld_alive = life_next(p2_reg, p1_reg, p0_reg);
                    if (fptr_last)
                        state_next = S_FEMLAST;
                    else
                    begin
                        fptr_next  = fptr_reg + COL_W'(1);
                        state_next = S_FRD;
                    end
                end
            end
            S_FEMLAST:
            begin
                ld_row = cur_row_reg;
                ld_col = fptr_reg;
                if (out_free)
                begin
                    ld         = 1'b1;
                    ld_alive   = life_next(p1_reg, p0_reg, '0);
                    ld_last    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // raster position of the next incoming cell
    always_comb
    begin
        pos_row_next = pos_row_reg;
        pos_col_next = pos_col_reg;
        if (cfg_we)
        begin
            pos_row_next = '0;
            pos_col_next = '0;
        end
        else if (accept)
        begin
            if (pos_col_last && pos_row_last)
            begin
                pos_row_next = '0;
                pos_col_next = '0;
            end
            else if (pos_col_last)
            begin
                pos_row_next = pos_row_reg + ROW_W'(1);
                pos_col_next = '0;
            end
            else
            begin
                pos_col_next = pos_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_row_reg   <= '0;
            pos_col_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_row_reg <= pos_row_next;
            pos_col_reg <= pos_col_next;
            if (ld)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        fptr_reg <= fptr_next;
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        if (accept)
        begin
            cur_row_reg  <= pos_row_reg;
            cur_col_reg  <= pos_col_reg;
            cell_reg     <= cell_alive;
            col_last_reg <= pos_col_last;
            final_reg    <= pos_col_last && pos_row_last;
        end
        if (ld)
        begin
            next_alive_reg <= ld_alive;
            out_row_reg    <= OUT_COORD_W'(ld_row);
            out_col_reg    <= OUT_COORD_W'(ld_col);
            run_last_reg   <= ld_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign next_alive = next_alive_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign run_last   = run_last_reg;

endmodule

// ----- rtl/core/lgs_row_mem.sv -----
// ----------------------------------------------------------------------------
// lgs_row_mem
// Column history memory: one entry per column, two rows deep, registered read.
// ----------------------------------------------------------------------------
module lgs_row_mem
    import lgs_pkg::*;
#(
    parameter int DEPTH = LGS_MAX_COLS
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [ENTRY_W-1:0]       wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [ENTRY_W-1:0]       rd_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/lgs_cfg.sv -----
// ----------------------------------------------------------------------------
// lgs_cfg
// Grid size registers with clamping to the supported range.
// ----------------------------------------------------------------------------
module lgs_cfg
    import lgs_pkg::*;
#(
    parameter int MAX_COLS = LGS_MAX_COLS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [CFG_W-1:0]                cfg_data,
    output logic [CFG_W-1:0]                rows_eff,
    output logic [$clog2(MAX_COLS+1)-1:0]   cols_eff
);

    localparam int COL_CNT_W = $clog2(MAX_COLS + 1);

    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= SIZE_RESET;
            cols_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS: rows_reg <= cfg_data;
                REG_COLS: cols_reg <= cfg_data;
                default:  rows_reg <= rows_reg;
            endcase
        end
    end

    // zero means one, oversize means the maximum
    always_comb
    begin
        if (rows_reg == '0)
            rows_eff = CFG_W'(1);
        else if (int'(rows_reg) > LGS_MAX_ROWS)
            rows_eff = CFG_W'(LGS_MAX_ROWS);
        else
            rows_eff = rows_reg;

        if (cols_reg == '0)
            cols_eff = COL_CNT_W'(1);
        else if (int'(cols_reg) > MAX_COLS)
            cols_eff = COL_CNT_W'(MAX_COLS);
        else
            cols_eff = COL_CNT_W'(cols_reg);
    end

endmodule
